@@ design/pcog_pkg.sv @@
// shared types, constants and helpers for the occupancy grid block
`default_nettype none

package pcog_pkg;

  // parameter defaults for the top level
  localparam int MaxPointsDef = 4096;
  localparam int GridDimDef   = 256;
  localparam int MaxKernelDef = 7;

  // fixed widths
  localparam int KW    = 4;   // kernel edge, up to 15
  localparam int DivW  = 34;  // divider dividend and quotient
  localparam int CellW = 16;  // divisor
  localparam int SizeW = 9;   // grid width and height

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_HEIGHT_MIN = 3'd0;
  localparam logic [2:0] CFG_HEIGHT_MAX = 3'd1;
  localparam logic [2:0] CFG_CELL_SIZE  = 3'd2;
  localparam logic [2:0] CFG_MAX_CELLS  = 3'd3;
  localparam logic [2:0] CFG_CLOSING    = 3'd4;
  localparam logic [2:0] CFG_KERNEL     = 3'd5;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
    logic [7:0]         read_row;
    logic [1:0]         read_word;
  } in_t;

  typedef struct packed {
    logic               map_valid;
    logic [8:0]         map_width;
    logic [8:0]         map_height;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [63:0]        row_bits;
  } out_t;

  // bounding box of the kept points
  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] max_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;
  } box_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_OUT,
    S_DIV_W_GO,
    S_DIV_W,
    S_DIV_H_GO,
    S_DIV_H,
    S_CLR,
    S_PT_ADDR,
    S_PT_LATCH,
    S_DX_GO,
    S_DX,
    S_DY_GO,
    S_DY,
    S_SET_RD,
    S_SET_WR,
    S_TAP_ADDR,
    S_TAP_DATA,
    S_WIN_WR,
    S_DONE
  } state_e;

  // negate, saturating the most negative value
  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == 32'sh8000_0000) begin
      r = 32'sh7fff_ffff;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/pcog_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none

module pcog_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pcog_pkg::DivW-1:0]  dividend_i,
  input  wire logic [pcog_pkg::CellW-1:0] divisor_i,
  output logic                           done_o,
  output logic [pcog_pkg::DivW-1:0]      quot_o
);
  import pcog_pkg::*;

  localparam int CntW = $clog2(DivW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] dvd_q, dvd_d;
  logic [CellW-1:0] rem_q, rem_d;
  logic [CellW-1:0] dsr_q, dsr_d;
  logic [CellW:0]  rem_sh;
  logic            ge;

  // load on start, otherwise one restoring step while busy
  always_comb begin
    rem_sh = {rem_q, dvd_q[DivW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? CellW'(rem_sh - {1'b0, dsr_q}) : CellW'(rem_sh);
      dvd_d = {dvd_q[DivW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

`default_nettype wire

@@ design/pcog_pts.sv @@
// point store, kept point count and bounding box
`default_nettype none

module pcog_pts #(
  parameter  int MAX_POINTS = pcog_pkg::MaxPointsDef,
  localparam int PA = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               ld_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  input  wire logic signed [31:0] z_i,
  input  wire logic signed [31:0] hmin_i,
  input  wire logic signed [31:0] hmax_i,
  input  wire logic               clear_i,
  input  wire logic [PA-1:0]      raddr_i,
  output logic [63:0]             rdata_o,
  output logic [CW-1:0]           count_o,
  output pcog_pkg::box_t          box_o
);
  import pcog_pkg::*;

  logic [63:0]        mem [MAX_POINTS];
  logic [CW-1:0]      count_q;
  box_t               box_q;
  logic               keep;
  logic signed [31:0] wx, wy;

  // height band and capacity test, world coordinates
  always_comb begin
    keep = (z_i >= hmin_i) && (z_i <= hmax_i) && (count_q < CW'(MAX_POINTS));
    wx   = neg_sat(y_i);
    wy   = neg_sat(x_i);
  end

  // count and box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      box_q.min_x <= 32'sh7fff_ffff;
      box_q.min_y <= 32'sh7fff_ffff;
      box_q.max_x <= 32'sh8000_0000;
      box_q.max_y <= 32'sh8000_0000;
    end else if (clear_i) begin
      count_q     <= '0;
      box_q.min_x <= 32'sh7fff_ffff;
      box_q.min_y <= 32'sh7fff_ffff;
      box_q.max_x <= 32'sh8000_0000;
      box_q.max_y <= 32'sh8000_0000;
    end else if (ld_i && keep) begin
      count_q <= count_q + CW'(1);
      if (wx < box_q.min_x) box_q.min_x <= wx;
      if (wx > box_q.max_x) box_q.max_x <= wx;
      if (wy < box_q.min_y) box_q.min_y <= wy;
      if (wy > box_q.max_y) box_q.max_y <= wy;
    end
  end

  // store write
  always_ff @(posedge clk_i) begin
    if (ld_i && keep) begin
      mem[PA'(count_q)] <= {wy, wx};
    end
  end

  // store read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

  assign count_o = count_q;
  assign box_o   = box_q;

endmodule

`default_nettype wire

@@ design/point_cloud_occupancy_grid.sv @@
// top level: occupancy grid build sequencer, grid memories and result port
//
// Usage. An item is taken when start is high and busy is low. A load item
// (opcode load) stores a point whose height lies in the band and updates the
// bounding box; it gives no result and leaves busy low, so loads can stream
// one per cycle. A load with last_point set starts a build and busy stays
// high until it ends. A read item returns one 64-bit grid word.
// Results appear on res_o for exactly one cycle with res_strobe_o high; the
// receiver cannot stall them.
// A read passes through an address and an output state, keeping busy high,
// and its result is registered after them. A build runs the two size
// divisions, clears the grid, then for each kept point runs two passes of
// the shared divider and a read-modify-write, and with closing on runs the
// four window passes; then the result follows.
// Reset clears the point count, the box, the map registers and marks the
// grid empty; reads before the first build return zero.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, the block itself does not enforce this.
`default_nettype none

module point_cloud_occupancy_grid #(
  parameter int MAX_POINTS = pcog_pkg::MaxPointsDef,
  parameter int GRID_DIM   = pcog_pkg::GridDimDef,
  parameter int MAX_KERNEL = pcog_pkg::MaxKernelDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire pcog_pkg::in_t item_i,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_data_i,
  output logic               res_strobe_o,
  output pcog_pkg::out_t     res_o
);
  import pcog_pkg::*;

  localparam int PA         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW         = $clog2(MAX_POINTS + 1);
  localparam int WPR        = (GRID_DIM + 63) / 64;
  localparam int GRID_WORDS = GRID_DIM * WPR;
  localparam int GA         = $clog2(GRID_WORDS);
  localparam int RW         = $clog2(GRID_DIM);
  localparam int WW         = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int GridLim    = (GRID_DIM > 511) ? 511 : GRID_DIM;

  // configuration registers
  logic signed [31:0] height_min_q, height_max_q;
  logic [15:0]        cell_size_q;
  logic [8:0]         max_cells_q;
  logic               closing_enable_q;
  logic [2:0]         kernel_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_min_q     <= 32'sh8000_0000;
      height_max_q     <= 32'sh7fff_ffff;
      cell_size_q      <= 16'd100;
      max_cells_q      <= 9'd256;
      closing_enable_q <= 1'b0;
      kernel_size_q    <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEIGHT_MIN: height_min_q     <= cfg_data_i;
        CFG_HEIGHT_MAX: height_max_q     <= cfg_data_i;
        CFG_CELL_SIZE:  cell_size_q      <= cfg_data_i[15:0];
        CFG_MAX_CELLS:  max_cells_q      <= cfg_data_i[8:0];
        CFG_CLOSING:    closing_enable_q <= cfg_data_i[0];
        CFG_KERNEL:     kernel_size_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // point store
  logic [63:0]   pts_rdata;
  logic [CW-1:0] pts_count;
  box_t          box;
  logic [PA-1:0] i_q;

  pcog_pts #(.MAX_POINTS(MAX_POINTS)) u_pts (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (accept && (item_i.opcode == OP_LOAD)),
    .x_i     (item_i.point_x),
    .y_i     (item_i.point_y),
    .z_i     (item_i.point_z),
    .hmin_i  (height_min_q),
    .hmax_i  (height_max_q),
    .clear_i (state_q == S_DONE),
    .raddr_i (i_q),
    .rdata_o (pts_rdata),
    .count_o (pts_count),
    .box_o   (box)
  );

  // shared divider
  logic            div_start, div_done;
  logic [DivW-1:0] div_dividend, div_quot;
  logic [CellW-1:0] cell_c;

  assign cell_c = (cell_size_q == '0) ? CellW'(1) : cell_size_q;

  pcog_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cell_c),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // map registers and working registers
  logic               map_ok_q, built_q;
  logic [SizeW-1:0]   w_q, h_q;
  logic signed [31:0] org_x_q, org_y_q;
  logic [GA-1:0]      rd_addr_q, clr_q;
  logic               rd_ok_q;
  logic [63:0]        pt_q;
  logic [RW-1:0]      gx_q, gy_q, r_q;
  logic               hitx_q, hit_q;
  logic [1:0]         pass_q;
  logic [WW-1:0]      j_q;
  logic [KW-1:0]      tap_q;
  logic [63:0]        win_q [3];
  logic [63:0]        acc_q;
  logic               strobe_q;
  out_t               res_q;

  // kernel edge and anchor, size limit and clamped quotient
  logic [KW-1:0]   k_c;
  logic [KW-2:0]   a_c;
  logic [SizeW-1:0] lim_c, qclamp_c;

  always_comb begin
    if (kernel_size_q == '0) begin
      k_c = KW'(1);
    end else if (KW'(kernel_size_q) > KW'(MAX_KERNEL)) begin
      k_c = KW'(MAX_KERNEL);
    end else begin
      k_c = KW'(kernel_size_q);
    end
    a_c      = k_c[KW-1:1];
    lim_c    = (max_cells_q > SizeW'(GridLim)) ? SizeW'(GridLim) : max_cells_q;
    qclamp_c = (div_quot > DivW'(lim_c)) ? lim_c : SizeW'(div_quot);
  end

  // pass decode: even passes horizontal, first two dilate
  logic horiz_c, erode_c;
  assign horiz_c = !pass_q[0];
  assign erode_c = pass_q[1];

  // window tap address
  logic          tap_ok;
  logic [GA-1:0] tap_addr;
  always_comb begin
    int jj;
    int rr;
    jj = int'(j_q) + int'(tap_q) - 1;
    rr = int'(r_q) + int'(tap_q) - int'(a_c);
    if (horiz_c) begin
      tap_ok   = (jj >= 0) && (jj < WPR);
      tap_addr = GA'(int'(r_q) * WPR + jj);
    end else begin
      tap_ok   = (rr >= 0) && (rr < int'(h_q));
      tap_addr = GA'(rr * WPR + int'(j_q));
    end
  end

  // read ports of both memories
  logic [63:0] grid_mem [GRID_WORDS];
  logic [63:0] scr_mem  [GRID_WORDS];
  logic [63:0] grid_rdata_q, scr_rdata_q, src_rdata;
  logic [GA-1:0] mem_raddr;

  assign src_rdata = pass_q[0] ? scr_rdata_q : grid_rdata_q;

  // window result word, window offsets run from -a to k-1-a
  logic [63:0] win_out;
  always_comb begin
    logic [191:0] win;
    logic [191:0] wsh;
    logic [63:0]  hbits;
    logic [63:0]  pre;
    logic         v;
    int           col;
    win = {win_q[2], win_q[1], win_q[0]};
    for (int b = 0; b < 192; b++) begin
      col = int'(j_q) * 64 - 64 + b;
      if (erode_c && ((col < 0) || (col >= int'(w_q)))) begin
        win[b] = 1'b1;
      end
    end
    wsh = win << a_c;
    for (int i = 0; i < 64; i++) begin
      v = erode_c;
      for (int dx = 0; dx < MAX_KERNEL; dx++) begin
        if (dx < int'(k_c)) begin
          v = erode_c ? (v & wsh[64 + i + dx]) : (v | wsh[64 + i + dx]);
        end
      end
      hbits[i] = v;
    end
    pre = horiz_c ? hbits : acc_q;
    for (int i = 0; i < 64; i++) begin
      col        = int'(j_q) * 64 + i;
      win_out[i] = pre[i] && (col < int'(w_q));
    end
  end

  // loop end conditions
  logic clr_last, pt_last, tap_last, word_last, row_last, pass_last;
  assign clr_last  = (clr_q == GA'(GRID_WORDS - 1));
  assign pt_last   = ((CW'(i_q) + CW'(1)) == pts_count);
  assign tap_last  = horiz_c ? (tap_q == KW'(2)) : (tap_q == (k_c - KW'(1)));
  assign word_last = (j_q == WW'(WPR - 1));
  assign row_last  = (r_q == RW'(h_q - SizeW'(1)));
  assign pass_last = (pass_q == 2'd3);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.opcode == OP_READ) begin
            state_d = S_RD_ADDR;
          end else if (item_i.last_point) begin
            state_d = S_DIV_W_GO;
          end
        end
      end
      S_RD_ADDR:  state_d = S_RD_OUT;
      S_RD_OUT:   state_d = S_IDLE;
      S_DIV_W_GO: state_d = S_DIV_W;
      S_DIV_W: begin
        if (div_done) state_d = S_DIV_H_GO;
      end
      S_DIV_H_GO: state_d = S_DIV_H;
      S_DIV_H: begin
        if (div_done) state_d = S_CLR;
      end
      S_CLR: begin
        if (clr_last) state_d = map_ok_q ? S_PT_ADDR : S_DONE;
      end
      S_PT_ADDR:  state_d = S_PT_LATCH;
      S_PT_LATCH: state_d = S_DX_GO;
      S_DX_GO:    state_d = S_DX;
      S_DX: begin
        if (div_done) state_d = S_DY_GO;
      end
      S_DY_GO:    state_d = S_DY;
      S_DY: begin
        if (div_done) state_d = S_SET_RD;
      end
      S_SET_RD:   state_d = S_SET_WR;
      S_SET_WR: begin
        if (pt_last) begin
          state_d = closing_enable_q ? S_TAP_ADDR : S_DONE;
        end else begin
          state_d = S_PT_ADDR;
        end
      end
      S_TAP_ADDR: state_d = S_TAP_DATA;
      S_TAP_DATA: state_d = tap_last ? S_WIN_WR : S_TAP_ADDR;
      S_WIN_WR: begin
        state_d = (word_last && row_last && pass_last) ? S_DONE : S_TAP_ADDR;
      end
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // memory and divider controls
  logic          grid_we, scr_we;
  logic [GA-1:0] grid_waddr, set_addr, win_addr;
  logic [63:0]   grid_wdata;
  logic [32:0]   ext_x, ext_y, dif_x, dif_y;

  always_comb begin
    ext_x    = {box.max_x[31], box.max_x} - {box.min_x[31], box.min_x};
    ext_y    = {box.max_y[31], box.max_y} - {box.min_y[31], box.min_y};
    dif_x    = {pt_q[31], pt_q[31:0]} - {org_x_q[31], org_x_q};
    dif_y    = {pt_q[63], pt_q[63:32]} - {org_y_q[31], org_y_q};
    set_addr = GA'(int'(gy_q) * WPR + (int'(gx_q) >> 6));
    win_addr = GA'(int'(r_q) * WPR + int'(j_q));

    div_start    = 1'b0;
    div_dividend = '0;
    unique case (state_q)
      S_DIV_W_GO: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, ext_x} + DivW'(cell_c) - DivW'(1);
      end
      S_DIV_H_GO: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, ext_y} + DivW'(cell_c) - DivW'(1);
      end
      S_DX_GO: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, dif_x};
      end
      S_DY_GO: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, dif_y};
      end
      default: ;
    endcase

    mem_raddr = '0;
    unique case (state_q)
      S_RD_ADDR:  mem_raddr = rd_addr_q;
      S_SET_RD:   mem_raddr = set_addr;
      S_TAP_ADDR: mem_raddr = tap_addr;
      default: ;
    endcase

    grid_we    = 1'b0;
    scr_we     = 1'b0;
    grid_waddr = win_addr;
    grid_wdata = win_out;
    unique case (state_q)
      S_CLR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_q;
        grid_wdata = '0;
      end
      S_SET_WR: begin
        grid_we    = hit_q;
        grid_waddr = set_addr;
        grid_wdata = grid_rdata_q | (64'd1 << gx_q[5:0]);
      end
      S_WIN_WR: begin
        grid_we = pass_q[0];
        scr_we  = !pass_q[0];
      end
      default: ;
    endcase
  end

  // grid memories
  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    grid_rdata_q <= grid_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) scr_mem[win_addr] <= win_out;
    scr_rdata_q <= scr_mem[mem_raddr];
  end

  // control state and map registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
      built_q  <= 1'b0;
      map_ok_q <= 1'b0;
      w_q      <= '0;
      h_q      <= '0;
      org_x_q  <= '0;
      org_y_q  <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == S_RD_OUT) || (state_q == S_DONE);
      if (state_q == S_CLR) built_q <= 1'b1;
      if ((state_q == S_DIV_W) && div_done) begin
        w_q     <= (pts_count != '0) ? qclamp_c : '0;
        org_x_q <= (pts_count != '0) ? box.min_x : '0;
        org_y_q <= (pts_count != '0) ? box.min_y : '0;
      end
      if ((state_q == S_DIV_H) && div_done) begin
        h_q      <= (pts_count != '0) ? qclamp_c : '0;
        map_ok_q <= (pts_count != '0) && (w_q != '0) && (qclamp_c != '0);
      end
    end
  end

  // sequencer working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        rd_addr_q <= GA'(32'(item_i.read_row) * WPR + 32'(item_i.read_word));
        rd_ok_q   <= (32'(item_i.read_row) < GRID_DIM) && (32'(item_i.read_word) < WPR);
      end
      S_DIV_H: clr_q <= '0;
      S_CLR: begin
        clr_q <= clr_q + GA'(1);
        i_q   <= '0;
      end
      S_PT_LATCH: pt_q <= pts_rdata;
      S_DX: begin
        gx_q   <= RW'(div_quot);
        hitx_q <= div_quot < DivW'(w_q);
      end
      S_DY: begin
        gy_q  <= RW'(div_quot);
        hit_q <= hitx_q && (div_quot < DivW'(h_q));
      end
      S_SET_WR: begin
        i_q    <= i_q + PA'(1);
        pass_q <= '0;
        r_q    <= '0;
        j_q    <= '0;
        tap_q  <= '0;
      end
      S_TAP_DATA: begin
        if (horiz_c) begin
          win_q[tap_q[1:0]] <= tap_ok ? src_rdata : '0;
        end
        if (tap_q == '0) begin
          if (!tap_ok) begin
            acc_q <= {64{erode_c}};
          end else begin
            acc_q <= src_rdata;
          end
        end else if (tap_ok) begin
          acc_q <= erode_c ? (acc_q & src_rdata) : (acc_q | src_rdata);
        end
        tap_q <= tap_q + KW'(1);
      end
      S_WIN_WR: begin
        tap_q <= '0;
        if (word_last) begin
          j_q <= '0;
          if (row_last) begin
            r_q    <= '0;
            pass_q <= pass_q + 2'd1;
          end else begin
            r_q <= r_q + RW'(1);
          end
        end else begin
          j_q <= j_q + WW'(1);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if ((state_q == S_RD_OUT) || (state_q == S_DONE)) begin
      res_q.map_valid  <= map_ok_q;
      res_q.map_width  <= w_q;
      res_q.map_height <= h_q;
      res_q.origin_x   <= org_x_q;
      res_q.origin_y   <= org_y_q;
      res_q.row_bits   <= ((state_q == S_RD_OUT) && rd_ok_q && built_q) ? grid_rdata_q : '0;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  // a result only follows a read or the end of a build
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> ($past(state_q) == S_RD_OUT || $past(state_q) == S_DONE))
    else $error("result without read or build");

  // a plain load leaves the block ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.opcode == OP_LOAD && !item_i.last_point) |=> !busy)
    else $error("plain load left block busy");

  // cells are only marked on a valid map
  a_mark_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SET_WR && hit_q) |-> map_ok_q)
    else $error("cell marked on invalid map");

  // divider finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_W || state_q == S_DIV_H ||
                  state_q == S_DX || state_q == S_DY))
    else $error("divider result not awaited");

endmodule

`default_nettype wire
